[rtl/dpsc_pkg.sv]
package dpsc_pkg;

  // Moving-average window: a power of two, so the divide is a shift.
  localparam int WIN_LOG     = 3;
  localparam int WINDOW      = 1 << WIN_LOG;
  localparam int SAMPLE_BITS = 12;

  localparam int SUM_W       = SAMPLE_BITS + WIN_LOG;
  localparam int ERR_W       = SAMPLE_BITS + 1;
  localparam int DERR_W      = ERR_W + 1;
  localparam int INTEG_W     = 12;
  localparam int INTEG_SUM_W = ((ERR_W > INTEG_W) ? ERR_W : INTEG_W) + 1;

  localparam int GAIN_W      = 8;
  localparam int ILIM_W      = 11;
  localparam int DLIM_W      = 12;

  localparam int PROD_P_W    = GAIN_W + 1 + ERR_W;
  localparam int PROD_I_W    = GAIN_W + 1 + INTEG_W;
  localparam int PROD_D_W    = GAIN_W + 1 + DERR_W;
  localparam int PID_W       = PROD_D_W + 2;
  localparam int AVG_SUM_W   = PID_W + 1;
  localparam int DRIVE_W     = 13;

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 12;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT = CFG_IDX_W'(4);

  localparam logic [GAIN_W-1:0] PROP_GAIN_RST   = GAIN_W'(8);
  localparam logic [GAIN_W-1:0] INTEG_GAIN_RST  = GAIN_W'(3);
  localparam logic [GAIN_W-1:0] DERIV_GAIN_RST  = GAIN_W'(1);
  localparam logic [ILIM_W-1:0] INTEG_LIMIT_RST = ILIM_W'(500);
  localparam logic [DLIM_W-1:0] DRIVE_LIMIT_RST = DLIM_W'(1800);

  typedef struct packed {
    logic [GAIN_W-1:0] prop_gain;
    logic [GAIN_W-1:0] integ_gain;
    logic [GAIN_W-1:0] deriv_gain;
    logic [ILIM_W-1:0] integ_limit;
    logic [DLIM_W-1:0] drive_limit;
  } cfg_t;

  // Load strobes for the pipeline stages, one per stage register.
  typedef struct packed {
    logic ld_fill;
    logic ld_err;
    logic ld_integ;
    logic ld_prod;
    logic ld_pid;
    logic ld_out;
  } stage_ctl_t;

endpackage

[rtl/dpsc_in_if.sv]
interface dpsc_in_if import dpsc_pkg::*;;
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] meas_right;
  logic signed [SAMPLE_BITS-1:0] meas_left;
  logic signed [SAMPLE_BITS-1:0] ref_right;
  logic signed [SAMPLE_BITS-1:0] ref_left;

  modport source (output valid, meas_right, meas_left, ref_right, ref_left, input ready);
  modport sink (input valid, meas_right, meas_left, ref_right, ref_left, output ready);
endinterface

[rtl/dpsc_out_if.sv]
interface dpsc_out_if import dpsc_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] drive_right;
  logic signed [DRIVE_W-1:0] drive_left;

  modport source (output valid, drive_right, drive_left, input ready);
  modport sink (input valid, drive_right, drive_left, output ready);
endinterface

[rtl/dpsc_motor.sv]
module dpsc_motor import dpsc_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  stage_ctl_t                    ctl,
  input  cfg_t                          cfg,
  input  logic [WIN_LOG-1:0]            slot,
  input  logic signed [SAMPLE_BITS-1:0] meas,
  input  logic signed [SAMPLE_BITS-1:0] ref_spd,
  output logic signed [DRIVE_W-1:0]     drive
);

  // Window and running sum.
  logic signed [SAMPLE_BITS-1:0] win_r [WINDOW];
  logic signed [SUM_W-1:0]       sum_r, sum_nxt;
  logic signed [SAMPLE_BITS-1:0] ref0_r;

  // Filtered speed and error.
  logic signed [SUM_W-1:0]       sum_adj;
  logic signed [SAMPLE_BITS-1:0] avg_spd;
  logic signed [ERR_W-1:0]       err1_r, err1_nxt;

  // Integrator and derivative term.
  logic signed [INTEG_SUM_W-1:0] isum, ilim;
  logic signed [INTEG_W-1:0]     integ_r, integ_nxt;
  logic signed [ERR_W-1:0]       prev_err_r;
  logic signed [ERR_W-1:0]       err2_r;
  logic signed [DERR_W-1:0]      derr2_r, derr_nxt;

  // Products and PID sum.
  logic signed [PROD_P_W-1:0]    pp_r, pp_nxt;
  logic signed [PROD_I_W-1:0]    ip_r, ip_nxt;
  logic signed [PROD_D_W-1:0]    dp_r, dp_nxt;
  logic signed [PID_W-1:0]       pid_r, pid_nxt;

  // Averaging with the previous drive and saturation.
  logic signed [AVG_SUM_W-1:0]   asum, asum_adj;
  logic signed [PID_W-1:0]       ahalf, dlim;
  logic signed [PID_W-1:0]       prev_drive_r;
  logic signed [DRIVE_W-1:0]     drive_r, drive_nxt;

  assign sum_nxt = sum_r - SUM_W'(win_r[slot]) + SUM_W'(meas);

  // Adding WINDOW-1 to a negative sum makes the shift truncate toward zero.
  assign sum_adj = sum_r + $signed({{(SUM_W - WIN_LOG){1'b0}}, {WIN_LOG{sum_r[SUM_W-1]}}});
  assign avg_spd = sum_adj[SUM_W-1:WIN_LOG];
  assign err1_nxt = ERR_W'(ref0_r) - ERR_W'(avg_spd);

  assign isum = INTEG_SUM_W'(integ_r) + INTEG_SUM_W'(err1_r);
  assign ilim = $signed({{(INTEG_SUM_W - ILIM_W){1'b0}}, cfg.integ_limit});
  always_comb begin
    priority if (isum > ilim) begin
      integ_nxt = INTEG_W'(ilim);
    end else if (isum < -ilim) begin
      integ_nxt = INTEG_W'(-ilim);
    end else begin
      integ_nxt = INTEG_W'(isum);
    end
  end
  assign derr_nxt = DERR_W'(err1_r) - DERR_W'(prev_err_r);

  assign pp_nxt = $signed({1'b0, cfg.prop_gain}) * err2_r;
  assign ip_nxt = $signed({1'b0, cfg.integ_gain}) * integ_r;
  assign dp_nxt = $signed({1'b0, cfg.deriv_gain}) * derr2_r;
  assign pid_nxt = PID_W'(pp_r) + PID_W'(ip_r) + PID_W'(dp_r);

  assign asum     = AVG_SUM_W'(pid_r) + AVG_SUM_W'(prev_drive_r);
  assign asum_adj = asum + $signed({{(AVG_SUM_W - 1){1'b0}}, asum[AVG_SUM_W-1]});
  assign ahalf    = asum_adj[AVG_SUM_W-1:1];
  assign dlim     = $signed({{(PID_W - DLIM_W){1'b0}}, cfg.drive_limit});
  always_comb begin
    priority if (ahalf > dlim) begin
      drive_nxt = DRIVE_W'(dlim);
    end else if (ahalf < -dlim) begin
      drive_nxt = DRIVE_W'(-dlim);
    end else begin
      drive_nxt = DRIVE_W'(ahalf);
    end
  end

  // Recurrent state: the window, integrator, previous error and previous drive.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW; i++) begin
        win_r[i] <= '0;
      end
      sum_r        <= '0;
      integ_r      <= '0;
      prev_err_r   <= '0;
      prev_drive_r <= '0;
    end else begin
      if (ctl.ld_fill) begin
        win_r[slot] <= meas;
        sum_r       <= sum_nxt;
      end
      if (ctl.ld_integ) begin
        integ_r    <= integ_nxt;
        prev_err_r <= err1_r;
      end
      if (ctl.ld_out) begin
        prev_drive_r <= ahalf;
      end
    end
  end

  // Stage payload registers.
  always_ff @(posedge clk) begin
    if (ctl.ld_fill) begin
      ref0_r <= ref_spd;
    end
    if (ctl.ld_err) begin
      err1_r <= err1_nxt;
    end
    if (ctl.ld_integ) begin
      err2_r  <= err1_r;
      derr2_r <= derr_nxt;
    end
    if (ctl.ld_prod) begin
      pp_r <= pp_nxt;
      ip_r <= ip_nxt;
      dp_r <= dp_nxt;
    end
    if (ctl.ld_pid) begin
      pid_r <= pid_nxt;
    end
    if (ctl.ld_out) begin
      drive_r <= drive_nxt;
    end
  end

  assign drive = drive_r;

endmodule

[rtl/dual_pid_speed_controller.sv]
// Channel   Dir  Handshake          Payload
// in_ch     in   valid/ready        meas_right, meas_left, ref_right, ref_left
// out_ch    out  valid/ready        drive_right, drive_left
// cfg_*     in   cfg_we (no wait)   cfg_idx selects the register, cfg_data the value
//
// One item is accepted per cycle while out_ch does not stall; each item passes
// through a six-stage pipeline per motor (window sum, error, integrator, products,
// PID sum, drive average and saturation). The pipeline advances as a whole
// whenever the output register is empty or being taken, so a stall on out_ch
// holds every stage and in_ch.ready drops. Reset clears the windows, integrators,
// previous error and drive, and loads the register defaults.
module dual_pid_speed_controller import dpsc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  dpsc_in_if.sink               in_ch,
  dpsc_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int NSTAGE = 6;

  cfg_t               cfg_r;
  logic [NSTAGE-1:0]  vld_r;
  logic [WIN_LOG-1:0] slot_r;
  logic               adv;
  stage_ctl_t         ctl;

  assign adv = !vld_r[NSTAGE-1] || out_ch.ready;

  assign ctl.ld_fill  = adv && in_ch.valid;
  assign ctl.ld_err   = adv && vld_r[0];
  assign ctl.ld_integ = adv && vld_r[1];
  assign ctl.ld_prod  = adv && vld_r[2];
  assign ctl.ld_pid   = adv && vld_r[3];
  assign ctl.ld_out   = adv && vld_r[4];

  assign in_ch.ready  = adv;
  assign out_ch.valid = vld_r[NSTAGE-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      slot_r <= '0;
    end else begin
      if (adv) begin
        vld_r <= {vld_r[NSTAGE-2:0], in_ch.valid};
      end
      if (ctl.ld_fill) begin
        slot_r <= slot_r + WIN_LOG'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain   <= PROP_GAIN_RST;
      cfg_r.integ_gain  <= INTEG_GAIN_RST;
      cfg_r.deriv_gain  <= DERIV_GAIN_RST;
      cfg_r.integ_limit <= INTEG_LIMIT_RST;
      cfg_r.drive_limit <= DRIVE_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_PROP_GAIN:   cfg_r.prop_gain   <= cfg_data[GAIN_W-1:0];
        REG_INTEG_GAIN:  cfg_r.integ_gain  <= cfg_data[GAIN_W-1:0];
        REG_DERIV_GAIN:  cfg_r.deriv_gain  <= cfg_data[GAIN_W-1:0];
        REG_INTEG_LIMIT: cfg_r.integ_limit <= cfg_data[ILIM_W-1:0];
        REG_DRIVE_LIMIT: cfg_r.drive_limit <= cfg_data[DLIM_W-1:0];
        default: begin
          // Writes to unused indexes are dropped.
        end
      endcase
    end
  end

  dpsc_motor u_right (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .cfg     (cfg_r),
    .slot    (slot_r),
    .meas    (in_ch.meas_right),
    .ref_spd (in_ch.ref_right),
    .drive   (out_ch.drive_right)
  );

  dpsc_motor u_left (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .cfg     (cfg_r),
    .slot    (slot_r),
    .meas    (in_ch.meas_left),
    .ref_spd (in_ch.ref_left),
    .drive   (out_ch.drive_left)
  );

endmodule
